FILE: hw/rtl/rcugp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcugp_pkg
// Shared types and constants for the RCU grace-period tracker.
// ----------------------------------------------------------------------------
package rcugp_pkg;

  localparam int MAX_CPUS = 64;
  localparam int CPU_W    = $clog2(MAX_CPUS);
  localparam int GEN_W    = 32;
  localparam int CNT_W    = 7;

  // event codes
  localparam logic OP_QUIESCENT = 1'b0;
  localparam logic OP_ENQUEUE   = 1'b1;

  typedef logic [GEN_W-1:0]    gen_t;
  typedef logic [MAX_CPUS-1:0] cpu_vec_t;

  typedef struct packed {
    logic             operation;
    logic [CPU_W-1:0] cpu;
  } req_t;

  typedef struct packed {
    logic dispatch_batch;
    gen_t current_generation;
    logic period_active;
    gen_t cpu_generation;
  } rsp_t;

  // state seen by the update logic for one request
  typedef struct packed {
    logic             op;
    logic [CNT_W-1:0] cpu_count;
    cpu_vec_t         qmask;
    gen_t             global_gen;
    gen_t             highest_gen;
    logic             cur_pend;
    logic             nxt_pend;
    gen_t             cpu_gen;
    logic [CPU_W-1:0] cpu;
  } step_in_t;

  // updated state for one request
  typedef struct packed {
    cpu_vec_t qmask;
    gen_t     global_gen;
    gen_t     highest_gen;
    logic     cur_pend;
    logic     nxt_pend;
    logic     gen_we;
    gen_t     cpu_gen;
    logic     dispatch;
  } step_out_t;

endpackage

FILE: hw/rtl/rcugp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcugp_step
// Combinational state update for one quiescent or enqueue request.
// ----------------------------------------------------------------------------
module rcugp_step (
  input  rcugp_pkg::step_in_t  st_i,
  output rcugp_pkg::step_out_t st_o
);
  import rcugp_pkg::*;

  cpu_vec_t full_mask;
  cpu_vec_t bit_sel;
  cpu_vec_t qm1;
  gen_t     gg1;
  cpu_vec_t qm2;
  gen_t     gg2;
  gen_t     hg2;
  logic     qhit;
  logic     disp;
  logic     cur1;
  logic     promote;
  gen_t     gen_prom;

  always_comb begin
    if (st_i.cpu_count >= CNT_W'(MAX_CPUS)) begin
      full_mask = '1;
    end else begin
      full_mask = (cpu_vec_t'(1) << st_i.cpu_count[CPU_W-1:0]) - cpu_vec_t'(1);
    end
  end

  always_comb begin
    bit_sel = cpu_vec_t'(1) << st_i.cpu;
    qhit    = |(st_i.qmask & bit_sel);
    qm1     = qhit ? (st_i.qmask & ~bit_sel) : st_i.qmask;

    // last CPU of the period reported: advance, restart if more is owed
    gg1 = st_i.global_gen;
    qm2 = qm1;
    hg2 = st_i.highest_gen;
    if (qhit && (qm1 == '0)) begin
      gg1 = st_i.global_gen + gen_t'(1);
    end
    gg2 = gg1;
    if (qhit && (qm1 == '0) && (gg1 <= st_i.highest_gen)) begin
      qm2 = full_mask;
      gg2 = gg1 + gen_t'(1);
      hg2 = gg2;
    end

    disp     = st_i.cur_pend && (gg2 > st_i.cpu_gen);
    cur1     = st_i.cur_pend && !disp;
    promote  = !cur1 && st_i.nxt_pend;
    gen_prom = gg2 + gen_t'(1);

    st_o.qmask       = qm2;
    st_o.global_gen  = gg2;
    st_o.highest_gen = hg2;
    st_o.cur_pend    = cur1;
    st_o.nxt_pend    = st_i.nxt_pend;
    st_o.gen_we      = 1'b0;
    st_o.cpu_gen     = st_i.cpu_gen;
    st_o.dispatch    = disp;

    if (promote) begin
      st_o.nxt_pend = 1'b0;
      st_o.cur_pend = 1'b1;
      st_o.gen_we   = 1'b1;
      st_o.cpu_gen  = gen_prom;
      if (qm2 != '0) begin
        st_o.highest_gen = gen_prom + gen_t'(1);
      end else begin
        st_o.qmask       = full_mask;
        st_o.global_gen  = gen_prom;
        st_o.highest_gen = gen_prom;
      end
    end

    // enqueue only arms the next batch
    if (st_i.op == OP_ENQUEUE) begin
      st_o.qmask       = st_i.qmask;
      st_o.global_gen  = st_i.global_gen;
      st_o.highest_gen = st_i.highest_gen;
      st_o.cur_pend    = st_i.cur_pend;
      st_o.nxt_pend    = 1'b1;
      st_o.gen_we      = 1'b0;
      st_o.cpu_gen     = st_i.cpu_gen;
      st_o.dispatch    = 1'b0;
    end
  end

endmodule

FILE: hw/rtl/rcu_grace_period_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcu_grace_period_tracker_core
// Classic RCU grace-period tracker: quiescent mask, generations, batch flags.
// ----------------------------------------------------------------------------
// Takes one request per clock (enqueue or quiescent report from a CPU) and
// returns one response per request, in order. The accepting edge loads the
// request and the per-CPU generation memory read into a stage register;
// stage 1 then runs the state update and loads the response register once
// that register is free or being drained. Sustained rate is one request per
// cycle, limited only by out_stall; a request is taken while a finished
// response waits.
// cfg_wr_data sets the number of CPUs in each new grace period (values of
// 64 and up mean all 64); write it only while no request is in flight.
// ----------------------------------------------------------------------------
module rcu_grace_period_tracker_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rcugp_pkg::req_t               in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rcugp_pkg::rsp_t               out_data,
  input  logic                          cfg_wr_en,
  input  logic [rcugp_pkg::CNT_W-1:0]   cfg_wr_data
);
  import rcugp_pkg::*;

  // architectural state
  logic [CNT_W-1:0] cnt_r;
  cpu_vec_t         qmask_r;
  gen_t             gg_r;
  gen_t             hg_r;
  cpu_vec_t         cur_pend_r;
  cpu_vec_t         nxt_pend_r;
  cpu_vec_t         gen_vld_r;     // entry written since reset, else reads 0
  gen_t             gen_mem_r [MAX_CPUS];

  // stage 1: request plus registered memory read
  logic             s1_valid_r;
  req_t             s1_data_r;
  gen_t             mem_q_r;
  logic             byp_hit_r;     // write to same CPU landed on the read edge
  gen_t             byp_gen_r;

  // response register
  logic             out_valid_r;
  rsp_t             out_data_r;

  logic             s1_adv;
  logic             in_acc;
  gen_t             cpu_gen_cur;
  step_in_t         st_in;
  step_out_t        st_out;

  // stage 1 moves on when the response register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // memory read raced by the update of the previous request: take the bypass
  always_comb begin
    if (!gen_vld_r[s1_data_r.cpu]) begin
      cpu_gen_cur = '0;
    end else if (byp_hit_r) begin
      cpu_gen_cur = byp_gen_r;
    end else begin
      cpu_gen_cur = mem_q_r;
    end
  end

  always_comb begin
    st_in.op          = s1_data_r.operation;
    st_in.cpu_count   = cnt_r;
    st_in.qmask       = qmask_r;
    st_in.global_gen  = gg_r;
    st_in.highest_gen = hg_r;
    st_in.cur_pend    = cur_pend_r[s1_data_r.cpu];
    st_in.nxt_pend    = nxt_pend_r[s1_data_r.cpu];
    st_in.cpu_gen     = cpu_gen_cur;
    st_in.cpu         = s1_data_r.cpu;
  end

  rcugp_step u_step (
    .st_i (st_in),
    .st_o (st_out)
  );

  // per-CPU generation memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (s1_adv && st_out.gen_we) begin
      gen_mem_r[s1_data_r.cpu] <= st_out.cpu_gen;
    end
    if (in_acc) begin
      mem_q_r   <= gen_mem_r[in_data.cpu];
      byp_gen_r <= st_out.cpu_gen;
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r.dispatch_batch     <= st_out.dispatch;
      out_data_r.current_generation <= st_out.global_gen;
      out_data_r.period_active      <= |st_out.qmask;
      out_data_r.cpu_generation     <= st_out.cpu_gen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CNT_W'(1);
      qmask_r     <= '0;
      gg_r        <= '0;
      hg_r        <= '0;
      cur_pend_r  <= '0;
      nxt_pend_r  <= '0;
      gen_vld_r   <= '0;
      s1_valid_r  <= 1'b0;
      byp_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cnt_r <= cfg_wr_data;
      end
      if (s1_adv) begin
        qmask_r                    <= st_out.qmask;
        gg_r                       <= st_out.global_gen;
        hg_r                       <= st_out.highest_gen;
        cur_pend_r[s1_data_r.cpu]  <= st_out.cur_pend;
        nxt_pend_r[s1_data_r.cpu]  <= st_out.nxt_pend;
        if (st_out.gen_we) begin
          gen_vld_r[s1_data_r.cpu] <= 1'b1;
        end
      end
      if (in_acc) begin
        byp_hit_r <= s1_adv && st_out.gen_we && (s1_data_r.cpu == in_data.cpu);
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
